// ===== sv/hvps_pkg.sv =====
// ----------------------------------------------------------------------------
// hvps_pkg
// shared types, codes, reset values and the feedback check for the
// high-voltage precharge sequencer
// ----------------------------------------------------------------------------
package hvps_pkg;

    // width of the millisecond time base, all time arithmetic wraps here
    localparam int TIME_BITS = 32;
    localparam int MON_BITS  = 17;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_INDEX_BITS = 3;

    // item kinds
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BYPASS_CHECKS    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BYPASS_DISCHARGE = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CONTACTOR_DELAY  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PRECHARGE_TIME   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE         = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOCKOUT          = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MONITOR_PERIOD   = 3'd6;

    // configuration reset values
    localparam logic [15:0] RST_CONTACTOR_DELAY = 16'd250;
    localparam logic [15:0] RST_PRECHARGE_TIME  = 16'd3000;
    localparam logic [15:0] RST_DEBOUNCE        = 16'd250;
    localparam logic [15:0] RST_LOCKOUT         = 16'd15000;
    localparam logic [15:0] RST_MONITOR_PERIOD  = 16'd10000;

    // expected feedback patterns: bit0 discharge, bit1 air neg, bit2 air pos,
    // bit3 precharge
    localparam logic [3:0] EXP_ALL_OPEN = 4'h0;
    localparam logic [3:0] EXP_NEG      = 4'h3;
    localparam logic [3:0] EXP_PRE      = 4'hB;
    localparam logic [3:0] EXP_ALL      = 4'hF;
    localparam logic [3:0] EXP_MAINS    = 4'h7;

    // contactor command bits
    localparam int CMD_NEG_BIT = 0;
    localparam int CMD_POS_BIT = 1;
    localparam int CMD_PRE_BIT = 2;

    typedef enum logic [4:0] {
        ST_RX       = 5'd0,
        ST_START    = 5'd1,
        ST_OPEN_ALL = 5'd2,
        ST_SW_NEG   = 5'd3,
        ST_WAIT_NEG = 5'd4,
        ST_CHK_NEG  = 5'd5,
        ST_SW_PRE   = 5'd6,
        ST_WAIT_PRE = 5'd7,
        ST_CHK_PRE  = 5'd8,
        ST_VER_CUR  = 5'd9,
        ST_VER_BUS  = 5'd10,
        ST_SW_POS   = 5'd11,
        ST_WAIT_POS = 5'd12,
        ST_CHK_POS  = 5'd13,
        ST_PRE_OFF  = 5'd14,
        ST_WAIT_OFF = 5'd15,
        ST_CHK_OFF  = 5'd16,
        ST_DONE     = 5'd17,
        ST_FAULT    = 5'd18,
        ST_KILL     = 5'd19
    } seq_code_t;

    typedef struct packed {
        logic        bypass_checks;
        logic        bypass_discharge;
        logic [15:0] settle_delay_ms;
        logic [15:0] precharge_time_ms;
        logic [15:0] debounce_ms;
        logic [15:0] lockout_ms;
        logic [15:0] monitor_period;
    } cfg_t;

    typedef struct packed {
        logic       operation;
        logic [3:0] pins;
        logic       current_ok;
        logic       bus_voltage_ok;
        logic [7:0] request_value;
    } item_t;

    typedef struct packed {
        seq_code_t                        seq_code;
        logic [TIME_BITS-1:0]             now_ms;
        logic [TIME_BITS-1:0]             wait_start;
        logic [TIME_BITS-1:0]             recheck_mark;
        logic [TIME_BITS-1:0]             ignore_until;
        logic [MON_BITS-1:0]              monitor_count;
        logic [3:0]                       feedback_latched;
        logic [3:0]                       debounce_pending;
        logic [3:0][TIME_BITS-1:0]        debounce_start;
        logic [3:0]                       prev_pin_levels;
        logic [2:0]                       contactor_cmds;
    } seq_state_t;

    typedef struct packed {
        logic       pass;
        logic       raise;
        logic       clear;
        logic [3:0] bits;
    } chk_t;

    typedef struct packed {
        logic [4:0] seq_state;
        logic       close_air_neg;
        logic       close_air_pos;
        logic       close_precharge;
        logic       mismatch_raise;
        logic       mismatch_clear;
        logic [3:0] mismatch_bits;
        logic [3:0] feedback_levels;
    } result_t;

    // compare latched feedback against an expected pattern
    function automatic chk_t hvps_check(
        input logic [3:0] latched,
        input logic [3:0] expect_bits,
        input logic       bypass_dis,
        input logic       bypass_chk
    );
        chk_t       c;
        logic [3:0] diff;
        diff = latched ^ expect_bits;
        if (bypass_dis)
        begin
            diff[0] = 1'b0;
        end
        c.pass  = (diff == 4'h0) || bypass_chk;
        c.raise = !c.pass;
        c.clear = c.pass;
        c.bits  = c.pass ? 4'h0 : diff;
        return c;
    endfunction

endpackage

// ===== sv/hv_precharge_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// hv_precharge_sequencer_top
// battery precharge sequencer with contactor feedback debounce, start/stop
// requests and a lockout window
// ----------------------------------------------------------------------------
// Each item is a one-millisecond tick (operation 0) carrying the raw contactor
// feedback pins and the current/bus-voltage flags, or a start/stop request
// frame (operation 1). Every item gives exactly one result item with the state
// code after the item, the contactor commands, the outcome of any feedback
// check made on that item and the latched feedback levels. The block takes one
// item per clock cycle while out_stall is low; an item is registered on entry,
// goes through one pass of the step logic and lands in the result register,
// and the result register lets a new item come in while an earlier result is
// still stalled. Out of reset the sequence state is fault, which moves to kill
// on the first tick; a start request then begins the precharge sequence.
// Configuration is written through cfg_write_en / cfg_index / cfg_data and is
// meant to change only while no item is in flight.
// ----------------------------------------------------------------------------
module hv_precharge_sequencer_top (
    input  logic                                 clk,
    input  logic                                 rst_n,

    // configuration write port
    input  logic                                 cfg_write_en,
    input  logic [hvps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [hvps_pkg::CFG_DATA_BITS-1:0]   cfg_data,

    // item input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 operation,
    input  logic                                 pin_discharge,
    input  logic                                 pin_air_neg,
    input  logic                                 pin_air_pos,
    input  logic                                 pin_precharge,
    input  logic                                 current_ok,
    input  logic                                 bus_voltage_ok,
    input  logic [7:0]                           request_value,

    // result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [4:0]                           seq_state,
    output logic                                 close_air_neg,
    output logic                                 close_air_pos,
    output logic                                 close_precharge,
    output logic                                 mismatch_raise,
    output logic                                 mismatch_clear,
    output logic [3:0]                           mismatch_bits,
    output logic [3:0]                           feedback_levels
);
    import hvps_pkg::*;

    // configuration registers
    cfg_t       cfg_reg;

    // input stage
    logic       in_valid_reg;
    item_t      item_reg;

    // sequencer state, updated when an item moves into the result register
    seq_state_t state_reg;
    seq_state_t state_next;

    // result stage
    logic       out_valid_reg;
    result_t    result_reg;
    result_t    result_next;

    logic       accept;
    logic       advance;

    // the input stage moves on whenever the result register is empty or drains
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    // configuration writes, out-of-range indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bypass_checks      <= 1'b1;
            cfg_reg.bypass_discharge   <= 1'b1;
            cfg_reg.settle_delay_ms    <= RST_CONTACTOR_DELAY;
            cfg_reg.precharge_time_ms  <= RST_PRECHARGE_TIME;
            cfg_reg.debounce_ms        <= RST_DEBOUNCE;
            cfg_reg.lockout_ms         <= RST_LOCKOUT;
            cfg_reg.monitor_period     <= RST_MONITOR_PERIOD;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_BYPASS_CHECKS:    cfg_reg.bypass_checks      <= cfg_data[0];
                CFG_BYPASS_DISCHARGE: cfg_reg.bypass_discharge   <= cfg_data[0];
                CFG_CONTACTOR_DELAY:  cfg_reg.settle_delay_ms    <= cfg_data;
                CFG_PRECHARGE_TIME:   cfg_reg.precharge_time_ms  <= cfg_data;
                CFG_DEBOUNCE:         cfg_reg.debounce_ms        <= cfg_data;
                CFG_LOCKOUT:          cfg_reg.lockout_ms         <= cfg_data;
                CFG_MONITOR_PERIOD:   cfg_reg.monitor_period     <= cfg_data;
                default:              cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    // one pass of the sequencer for the item in the input stage
    hvps_step u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // handshake control and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{seq_code: ST_FAULT, default: '0};
        end
        else
        begin
            in_valid_reg  <= accept || (in_valid_reg && !advance);
            out_valid_reg <= advance || (out_valid_reg && out_stall);
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.operation      <= operation;
            item_reg.pins           <= {pin_precharge, pin_air_pos, pin_air_neg, pin_discharge};
            item_reg.current_ok     <= current_ok;
            item_reg.bus_voltage_ok <= bus_voltage_ok;
            item_reg.request_value  <= request_value;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign seq_state       = result_reg.seq_state;
    assign close_air_neg   = result_reg.close_air_neg;
    assign close_air_pos   = result_reg.close_air_pos;
    assign close_precharge = result_reg.close_precharge;
    assign mismatch_raise  = result_reg.mismatch_raise;
    assign mismatch_clear  = result_reg.mismatch_clear;
    assign mismatch_bits   = result_reg.mismatch_bits;
    assign feedback_levels = result_reg.feedback_levels;

endmodule

// ===== sv/hvps_step.sv =====
// ----------------------------------------------------------------------------
// hvps_step
// one item of work: debounce update and one sequencer step on a tick, or
// start/stop handling on a request frame
// ----------------------------------------------------------------------------
module hvps_step (
    input  hvps_pkg::seq_state_t state,
    input  hvps_pkg::cfg_t       cfg,
    input  hvps_pkg::item_t      item,
    output hvps_pkg::seq_state_t state_next,
    output hvps_pkg::result_t    result
);
    import hvps_pkg::*;

    always_comb
    begin
        seq_state_t           st;
        chk_t                 chk;
        logic [TIME_BITS-1:0] since_wait;
        logic [TIME_BITS-1:0] since_recheck;
        logic [TIME_BITS-1:0] since_edge;
        logic [TIME_BITS-1:0] since_lock;
        logic [TIME_BITS-1:0] cdelay;
        logic                 edge_seen;

        st            = state;
        chk           = '0;
        since_wait    = '0;
        since_recheck = '0;
        since_edge    = '0;
        since_lock    = '0;
        cdelay        = TIME_BITS'(cfg.settle_delay_ms);
        edge_seen     = 1'b0;

        if (item.operation == OP_TICK)
        begin
            st.now_ms = state.now_ms + TIME_BITS'(1);

            // edge latch, then debounce resample, per pin
            for (int i = 0; i < 4; i++)
            begin
                edge_seen = (item.pins[i] != state.prev_pin_levels[i])
                            && !state.debounce_pending[i];
                if (edge_seen)
                begin
                    st.feedback_latched[i] = item.pins[i];
                    st.debounce_pending[i] = 1'b1;
                    st.debounce_start[i]   = st.now_ms;
                end
                st.prev_pin_levels[i] = item.pins[i];
                since_edge = st.now_ms - st.debounce_start[i];
                if (st.debounce_pending[i] && (since_edge >= TIME_BITS'(cfg.debounce_ms)))
                begin
                    st.feedback_latched[i] = item.pins[i];
                    st.debounce_pending[i] = 1'b0;
                end
            end

            since_wait    = st.now_ms - st.wait_start;
            since_recheck = st.now_ms - st.recheck_mark;

            unique case (state.seq_code)
                ST_RX:
                begin
                    st.seq_code   = ST_START;
                    st.wait_start = '0;
                end
                ST_START:
                begin
                    st.contactor_cmds = 3'b000;
                    st.seq_code       = ST_OPEN_ALL;
                end
                ST_OPEN_ALL:
                begin
                    chk = hvps_check(st.feedback_latched, EXP_ALL_OPEN,
                                     cfg.bypass_discharge, cfg.bypass_checks);
                    if (chk.pass)
                    begin
                        st.seq_code = ST_SW_NEG;
                    end
                end
                ST_SW_NEG:
                begin
                    st.contactor_cmds[CMD_NEG_BIT] = 1'b1;
                    st.wait_start = st.now_ms;
                    st.seq_code   = ST_WAIT_NEG;
                end
                ST_WAIT_NEG:
                begin
                    if (since_wait >= cdelay)
                    begin
                        st.seq_code = ST_CHK_NEG;
                    end
                end
                ST_CHK_NEG:
                begin
                    chk = hvps_check(st.feedback_latched, EXP_NEG,
                                     cfg.bypass_discharge, cfg.bypass_checks);
                    st.seq_code = chk.pass ? ST_SW_PRE : ST_FAULT;
                end
                ST_SW_PRE:
                begin
                    st.contactor_cmds[CMD_PRE_BIT] = 1'b1;
                    st.wait_start   = st.now_ms;
                    st.recheck_mark = st.now_ms;
                    st.seq_code     = ST_WAIT_PRE;
                end
                ST_WAIT_PRE:
                begin
                    priority if (since_wait >= TIME_BITS'(cfg.precharge_time_ms))
                    begin
                        st.seq_code = ST_CHK_PRE;
                    end
                    else if ((since_recheck >= cdelay) && !cfg.bypass_checks)
                    begin
                        st.recheck_mark = state.recheck_mark + cdelay;
                        chk = hvps_check(st.feedback_latched, EXP_PRE,
                                         cfg.bypass_discharge, cfg.bypass_checks);
                        if (!chk.pass)
                        begin
                            st.seq_code = ST_FAULT;
                        end
                    end
                    else
                    begin
                        st.seq_code = ST_WAIT_PRE;
                    end
                end
                ST_CHK_PRE:
                begin
                    chk = hvps_check(st.feedback_latched, EXP_PRE,
                                     cfg.bypass_discharge, cfg.bypass_checks);
                    st.seq_code = chk.pass ? ST_VER_CUR : ST_FAULT;
                end
                ST_VER_CUR:
                begin
                    st.seq_code = (item.current_ok || cfg.bypass_checks) ? ST_VER_BUS : ST_FAULT;
                end
                ST_VER_BUS:
                begin
                    st.seq_code = (item.bus_voltage_ok || cfg.bypass_checks) ? ST_SW_POS
                                                                              : ST_FAULT;
                end
                ST_SW_POS:
                begin
                    st.contactor_cmds[CMD_POS_BIT] = 1'b1;
                    st.wait_start = st.now_ms;
                    st.seq_code   = ST_WAIT_POS;
                end
                ST_WAIT_POS:
                begin
                    if (since_wait >= cdelay)
                    begin
                        st.seq_code = ST_CHK_POS;
                    end
                end
                ST_CHK_POS:
                begin
                    chk = hvps_check(st.feedback_latched, EXP_ALL,
                                     cfg.bypass_discharge, cfg.bypass_checks);
                    st.seq_code = chk.pass ? ST_PRE_OFF : ST_FAULT;
                end
                ST_PRE_OFF:
                begin
                    st.contactor_cmds[CMD_PRE_BIT] = 1'b0;
                    st.wait_start = st.now_ms;
                    st.seq_code   = ST_WAIT_OFF;
                end
                ST_WAIT_OFF:
                begin
                    if (since_wait >= cdelay)
                    begin
                        st.seq_code = ST_CHK_OFF;
                    end
                end
                ST_CHK_OFF:
                begin
                    chk = hvps_check(st.feedback_latched, EXP_MAINS,
                                     cfg.bypass_discharge, cfg.bypass_checks);
                    st.seq_code = chk.pass ? ST_DONE : ST_FAULT;
                end
                ST_DONE:
                begin
                    if (state.monitor_count > MON_BITS'(cfg.monitor_period))
                    begin
                        st.monitor_count = '0;
                        chk = hvps_check(st.feedback_latched, EXP_MAINS,
                                         cfg.bypass_discharge, cfg.bypass_checks);
                        if (!chk.pass)
                        begin
                            st.seq_code = ST_KILL;
                        end
                    end
                    else
                    begin
                        st.monitor_count = state.monitor_count + MON_BITS'(1);
                    end
                end
                ST_FAULT:
                begin
                    st.wait_start = '0;
                    st.seq_code   = ST_KILL;
                end
                ST_KILL:
                begin
                    st.contactor_cmds = 3'b000;
                end
                default:
                begin
                    st.seq_code = ST_FAULT;
                end
            endcase
        end
        else
        begin
            // request frame: time stands still, pins are ignored
            if (item.request_value != 8'd0)
            begin
                since_lock = state.now_ms - state.ignore_until;
                if ((state.seq_code == ST_KILL) && !since_lock[TIME_BITS-1])
                begin
                    st.seq_code     = ST_RX;
                    st.ignore_until = state.now_ms + TIME_BITS'(cfg.lockout_ms);
                end
            end
            else
            begin
                st.seq_code     = ST_KILL;
                st.ignore_until = '0;
            end
        end

        state_next             = st;
        result.seq_state       = 5'(st.seq_code);
        result.close_air_neg   = st.contactor_cmds[CMD_NEG_BIT];
        result.close_air_pos   = st.contactor_cmds[CMD_POS_BIT];
        result.close_precharge = st.contactor_cmds[CMD_PRE_BIT];
        result.mismatch_raise  = chk.raise;
        result.mismatch_clear  = chk.clear;
        result.mismatch_bits   = chk.bits;
        result.feedback_levels = st.feedback_latched;
    end

endmodule
